// ----- rtl/core/naf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naf_pkg
// Shared types and constants of the Annex B framer: NAL type codes, the
// emulation prevention byte and the framing command passed front to back.
// ----------------------------------------------------------------------------
package naf_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;
    localparam logic [7:0] EP_BYTE       = 8'h03;
    localparam logic [7:0] EP_LIMIT      = 8'h03;
    localparam logic [7:0] SC_LAST_BYTE  = 8'h01;

    // One framing command describes every output byte caused by one item.
    typedef struct packed {
        logic                  sc_en;     // start code, header byte follows
        logic                  sc_long;   // four-byte start code
        logic                  pt_head;   // copy 00 00 00 01 unchanged
        logic [7:0]            hdr;       // NAL header byte
        logic [2:0][7:0]       pay;       // payload bytes, entry 0 first
        logic [1:0]            pay_cnt;   // number of payload bytes
        logic                  pay_ep;    // payload gets emulation prevention
        logic                  last;      // item ends the NAL
    } cmd_t;

endpackage

// ----- rtl/core/naf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naf_front
// Accepts raw NAL bytes, holds the first three bytes of a NAL and turns each
// item that causes output into a framing command for the output sequencer.
// ----------------------------------------------------------------------------
module naf_front
    import naf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic [1:0] s_tuser,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [2:0][7:0] head_reg;
    logic [1:0]      hcnt_reg, hcnt_next;
    logic            pt_reg, pt_next;
    logic            lcp_reg, lcp_next;
    logic            accept;
    logic            first, pic;
    logic            lcp_eff;
    logic            has_out;
    logic [7:0]      hdr_sel;
    logic [4:0]      kind;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign first    = s_tuser[0];
    assign pic      = s_tuser[1];
    assign lcp_eff  = lcp_reg || (first && pic);
    assign hdr_sel  = first ? s_tdata : head_reg[0];
    assign kind     = hdr_sel[4:0] & NAL_TYPE_MASK;
    assign q_push   = accept && has_out;

    always_comb begin
        q_cmd         = '0;
        q_cmd.hdr     = hdr_sel;
        q_cmd.sc_long = lcp_eff || (kind == NAL_TYPE_SPS) || (kind == NAL_TYPE_PPS);
        q_cmd.last    = s_tlast;
        q_cmd.pay_ep  = 1'b1;
        has_out       = 1'b0;
        hcnt_next     = hcnt_reg;
        pt_next       = pt_reg;
        lcp_next      = lcp_eff;
        priority if (first) begin
            pt_next = 1'b0;
            if (s_tlast) begin
                has_out     = 1'b1;
                q_cmd.sc_en = 1'b1;
                hcnt_next   = 2'd0;
                lcp_next    = 1'b0;
            end else begin
                hcnt_next = 2'd1;
            end
        end else if (hcnt_reg == 2'd0) begin
            has_out       = 1'b1;
            q_cmd.pay[0]  = s_tdata;
            q_cmd.pay_cnt = 2'd1;
            q_cmd.pay_ep  = !pt_reg;
        end else if (hcnt_reg != 2'd3) begin
            hcnt_next = hcnt_reg + 2'd1;
            if (s_tlast) begin
                has_out       = 1'b1;
                q_cmd.sc_en   = 1'b1;
                q_cmd.pay[0]  = (hcnt_reg == 2'd1) ? s_tdata : head_reg[1];
                q_cmd.pay[1]  = s_tdata;
                q_cmd.pay_cnt = hcnt_reg;
                hcnt_next     = 2'd0;
                lcp_next      = 1'b0;
            end
        end else begin
            has_out   = 1'b1;
            hcnt_next = 2'd0;
            if (head_reg[0] == 8'h00 && head_reg[1] == 8'h00 &&
                head_reg[2] == 8'h00 && s_tdata == SC_LAST_BYTE) begin
                q_cmd.pt_head = 1'b1;
                pt_next       = 1'b1;
            end else begin
                q_cmd.sc_en   = 1'b1;
                q_cmd.pay[0]  = head_reg[1];
                q_cmd.pay[1]  = head_reg[2];
                q_cmd.pay[2]  = s_tdata;
                q_cmd.pay_cnt = 2'd3;
                pt_next       = 1'b0;
                lcp_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hcnt_reg <= 2'd0;
            pt_reg   <= 1'b0;
            lcp_reg  <= 1'b1;
        end else if (accept) begin
            hcnt_reg <= hcnt_next;
            pt_reg   <= pt_next;
            lcp_reg  <= lcp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (first) begin
                head_reg[0] <= s_tdata;
            end else if (hcnt_reg == 2'd1 || hcnt_reg == 2'd2) begin
                head_reg[hcnt_reg] <= s_tdata;
            end
        end
    end

endmodule

// ----- rtl/core/naf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naf_queue
// Short command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module naf_queue
    import naf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign valid   = (cnt_reg != '0);
    assign cmd     = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/naf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naf_back
// Output sequencer: expands framing commands into start code, header and
// payload bytes, inserts emulation prevention bytes, and drives the output
// register.
// ----------------------------------------------------------------------------
module naf_back
    import naf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    localparam logic [1:0] PH_SC  = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;
    localparam logic [1:0] PH_PT  = 2'd3;

    cmd_t       cmd_reg;
    logic       busy_reg;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] idx_reg, idx_next;
    logic       epd_reg, epd_next;
    logic [1:0] zr_reg, zr_next;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg, m_ins_reg, m_lor_reg;

    logic [7:0] cur_byte, pay_byte;
    logic       cur_ins, cur_done;
    logic       adv, pop_slot;
    logic [1:0] start_phase, start_pos;

    assign pay_byte = cmd_reg.pay[idx_reg];
    assign adv      = busy_reg && (!m_valid_reg || m_tready);
    assign pop_slot = !busy_reg || (adv && cur_done);
    assign q_pop    = pop_slot && q_valid;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_lor_reg, m_ins_reg};

    always_comb begin
        priority if (q_cmd.sc_en) begin
            start_phase = PH_SC;
            start_pos   = q_cmd.sc_long ? 2'd0 : 2'd1;
        end else if (q_cmd.pt_head) begin
            start_phase = PH_PT;
            start_pos   = 2'd0;
        end else begin
            start_phase = PH_PAY;
            start_pos   = 2'd0;
        end
    end

    always_comb begin
        cur_byte   = 8'h00;
        cur_ins    = 1'b0;
        cur_done   = 1'b0;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        epd_next   = epd_reg;
        zr_next    = zr_reg;
        unique case (phase_reg)
            PH_SC: begin
                cur_byte = (pos_reg == 2'd3) ? SC_LAST_BYTE : 8'h00;
                cur_ins  = 1'b1;
                if (pos_reg == 2'd3) begin
                    phase_next = PH_HDR;
                end else begin
                    pos_next = pos_reg + 2'd1;
                end
            end
            PH_HDR: begin
                cur_byte = cmd_reg.hdr;
                zr_next  = 2'd0;
                if (cmd_reg.pay_cnt == 2'd0) begin
                    cur_done = 1'b1;
                end else begin
                    phase_next = PH_PAY;
                    idx_next   = 2'd0;
                    epd_next   = 1'b0;
                end
            end
            PH_PAY: begin
                if (cmd_reg.pay_ep && zr_reg == 2'd2 && pay_byte <= EP_LIMIT && !epd_reg) begin
                    cur_byte = EP_BYTE;
                    cur_ins  = 1'b1;
                    zr_next  = 2'd0;
                    epd_next = 1'b1;
                end else begin
                    cur_byte = pay_byte;
                    epd_next = 1'b0;
                    if (cmd_reg.pay_ep) begin
                        if (pay_byte != 8'h00) begin
                            zr_next = 2'd0;
                        end else if (zr_reg != 2'd2) begin
                            zr_next = zr_reg + 2'd1;
                        end
                    end
                    if (idx_reg == cmd_reg.pay_cnt - 2'd1) begin
                        cur_done = 1'b1;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            PH_PT: begin
                cur_byte = (pos_reg == 2'd3) ? SC_LAST_BYTE : 8'h00;
                zr_next  = 2'd0;
                if (pos_reg == 2'd3) begin
                    cur_done = 1'b1;
                end else begin
                    pos_next = pos_reg + 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_SC;
            pos_reg     <= 2'd0;
            idx_reg     <= 2'd0;
            epd_reg     <= 1'b0;
            zr_reg      <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop_slot) begin
                busy_reg <= q_valid;
            end
            if (q_pop) begin
                phase_reg <= start_phase;
                pos_reg   <= start_pos;
                idx_reg   <= 2'd0;
                epd_reg   <= 1'b0;
            end else if (adv) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                idx_reg   <= idx_next;
                epd_reg   <= epd_next;
            end
            if (adv) begin
                zr_reg <= zr_next;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (adv) begin
            m_data_reg <= cur_byte;
            m_ins_reg  <= cur_ins;
            m_lor_reg  <= cur_done;
            m_last_reg <= cur_done && cmd_reg.last;
        end
    end

    a_zero_run_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        zr_reg != 2'd3)
        else $error("Zero run counter passed saturation.");

    a_pay_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && phase_reg == PH_PAY) |-> (idx_reg < cmd_reg.pay_cnt))
        else $error("Payload index beyond the command's byte count.");

    a_ep_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && phase_reg == PH_PAY && cur_ins) |=> (busy_reg && phase_reg == PH_PAY))
        else $error("Emulation prevention byte not followed by its payload byte.");

    a_eon_on_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> m_lor_reg)
        else $error("End of NAL marked on a byte that does not end its item.");

endmodule

// ----- rtl/core/nal_annexb_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_annexb_framer
// H.264 NAL unit bytes in, Annex B byte stream out, with start code
// insertion and emulation prevention.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle whenever the command queue has
// room; the output side delivers one byte per cycle while commands wait and
// the output is not stalled. An item causes up to 9 output bytes (a four-byte
// start code, the header, three payload bytes and one emulation prevention
// byte before the last of them), and an item that only stores a head byte
// causes no output. The queue holds QUEUE_DEPTH framing commands, so the input
// keeps running while start codes and inserted bytes go out. Between acceptance
// and output, the first byte of an item passes the command queue, the command
// register of the output sequencer and the output register.
module nal_annexb_framer
    import naf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // last_of_nal
    input  logic [1:0] s_tuser,   // first_of_nal, first_of_picture
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // end_of_nal
    output logic [1:0] m_tuser    // inserted, last_of_run
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    naf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    naf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .cmd      (head_cmd)
    );

    naf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
